[hw/rtl/dad_pkg.sv]
`default_nettype none

package dad_pkg;

   localparam logic [13:0] YEAR_MAX    = 14'd9999;
   localparam logic [12:0] DIV100_MUL  = 13'd5243;
   localparam int          DIV100_SHIFT = 19;
   localparam logic [6:0]  CENTURY     = 7'd100;
   localparam logic [6:0]  CENTURY_END = 7'd99;
   localparam logic [8:0]  LEAP_DAYS   = 9'd366;
   localparam logic [8:0]  COMMON_DAYS = 9'd365;
   localparam logic [3:0]  MONTH_FIRST = 4'd1;
   localparam logic [3:0]  MONTH_LAST  = 4'd12;
   localparam logic [4:0]  DAY_FIRST   = 5'd1;
   localparam logic [4:0]  DAY_LAST    = 5'd31;

   localparam logic [1:0]  ST_OK  = 2'd0;
   localparam logic [1:0]  ST_BAD = 2'd1;
   localparam logic [1:0]  ST_OVF = 2'd2;

   typedef struct packed {
      logic [13:0] start_year;
      logic [3:0]  start_month;
      logic [4:0]  start_day;
      logic [15:0] days_to_add;
   } req_type;

   typedef struct packed {
      logic [13:0] result_year;
      logic [3:0]  result_month;
      logic [4:0]  result_day;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_DIV,
      OP_REM,
      OP_YEAR,
      OP_MONTH,
      OP_SAT,
      OP_BAD,
      OP_DONE
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_BAD,
      C_ZERO,
      C_YEAR_FITS,
      C_NO_OVF
   } cond_type;

   typedef struct packed {
      op_type     op;
      cond_type   cond;
      logic [3:0] target;
   } uword_type;

   localparam logic [3:0] PC_DIV    = 4'd0;
   localparam logic [3:0] PC_REM    = 4'd1;
   localparam logic [3:0] PC_CHECK  = 4'd2;
   localparam logic [3:0] PC_LOOP   = 4'd3;
   localparam logic [3:0] PC_PICK   = 4'd4;
   localparam logic [3:0] PC_MONTH  = 4'd5;
   localparam logic [3:0] PC_YEAR   = 4'd6;
   localparam logic [3:0] PC_OVF    = 4'd7;
   localparam logic [3:0] PC_SAT    = 4'd8;
   localparam logic [3:0] PC_BAD    = 4'd9;
   localparam logic [3:0] PC_DONE   = 4'd10;

   function automatic uword_type microcode(input logic [3:0] pc);
      uword_type w;
      unique case (pc)
         PC_DIV:   w = '{op: OP_DIV,   cond: C_NEVER,     target: PC_DIV};
         PC_REM:   w = '{op: OP_REM,   cond: C_NEVER,     target: PC_DIV};
         PC_CHECK: w = '{op: OP_NOP,   cond: C_BAD,       target: PC_BAD};
         PC_LOOP:  w = '{op: OP_NOP,   cond: C_ZERO,      target: PC_DONE};
         PC_PICK:  w = '{op: OP_NOP,   cond: C_YEAR_FITS, target: PC_YEAR};
         PC_MONTH: w = '{op: OP_MONTH, cond: C_ALWAYS,    target: PC_OVF};
         PC_YEAR:  w = '{op: OP_YEAR,  cond: C_NEVER,     target: PC_DIV};
         PC_OVF:   w = '{op: OP_NOP,   cond: C_NO_OVF,    target: PC_LOOP};
         PC_SAT:   w = '{op: OP_SAT,   cond: C_ALWAYS,    target: PC_DONE};
         PC_BAD:   w = '{op: OP_BAD,   cond: C_NEVER,     target: PC_DIV};
         PC_DONE:  w = '{op: OP_DONE,  cond: C_NEVER,     target: PC_DIV};
         default:  w = '{op: OP_DONE,  cond: C_NEVER,     target: PC_DIV};
      endcase
      return w;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/date_add_days.sv]
// gregorian date plus a day count
// request: a date (year, month, day) and a day count on req_data, taken at a
// rising edge with start high and busy low; busy then stays high until the
// result is out
// response: one result per request on rsp_data, shown for exactly one cycle
// with rsp_valid high; status 0 ok, 1 invalid date (date fields zero),
// 2 year overflow (date held at 9999-12-31); the receiver cannot stall
// a microcoded sequencer walks the calendar, skipping whole years from
// january 1 and single months otherwise; each skip is one pass of a
// four-step loop
// the next request is taken in the cycle after rsp_valid, or already while
// rsp_valid is high
// DAY_COUNT_BITS sets how many low bits of days_to_add are used
// reset: synchronous, active high; clears the sequencer and the response
// strobe, no request in flight survives it
`default_nettype none

module date_add_days #(
   parameter int DAY_COUNT_BITS = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire dad_pkg::req_type req_data,
   output logic                 busy,
   output logic                 rsp_valid,
   output dad_pkg::rsp_type     rsp_data
);

   localparam int CMP_W = DAY_COUNT_BITS + 9;
   localparam int PROD_W = 27;

   logic                      running_ff, running_in;
   logic [3:0]                pc_ff, pc_in;
   logic [13:0]               y_ff, y_in;
   logic [3:0]                m_ff, m_in;
   logic [4:0]                d_ff, d_in;
   logic [DAY_COUNT_BITS-1:0] n_ff, n_in;
   logic [7:0]                q_ff, q_in;
   logic [6:0]                r_ff, r_in;
   logic                      ovf_ff, ovf_in;
   logic [1:0]                st_ff, st_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   dad_pkg::rsp_type          rsp_ff, rsp_in;

   dad_pkg::uword_type        uw;
   logic                      accept;
   logic                      leap;
   logic [4:0]                mlen;
   logic [8:0]                ylen;
   logic [4:0]                left;
   logic                      bad;
   logic                      year_fits;
   logic                      fits_month;
   logic                      jump;
   logic [PROD_W-1:0]         prod;
   logic [14:0]               r_calc;
   logic [CMP_W-1:0]          n_ext;
   logic [DAY_COUNT_BITS+15:0] n_wide;

   assign accept = start && !running_ff;
   assign uw     = dad_pkg::microcode(pc_ff);
   assign leap   = (r_ff == '0) ? (q_ff[1:0] == 2'd0) : (y_ff[1:0] == 2'd0);
   assign mlen   = dad_pkg::month_len(m_ff, leap);
   assign ylen   = leap ? dad_pkg::LEAP_DAYS : dad_pkg::COMMON_DAYS;
   assign left   = mlen - d_ff;
   assign n_ext  = CMP_W'(n_ff);
   assign n_wide = {{DAY_COUNT_BITS{1'b0}}, req_data.days_to_add};
   assign prod   = PROD_W'(y_ff) * PROD_W'(dad_pkg::DIV100_MUL);
   assign r_calc = 15'(y_ff) - 15'(q_ff) * 15'(dad_pkg::CENTURY);

   assign bad = (y_ff > dad_pkg::YEAR_MAX) || (m_ff < dad_pkg::MONTH_FIRST) ||
                (m_ff > dad_pkg::MONTH_LAST) || (d_ff == '0) || (d_ff > mlen);
   assign year_fits = (m_ff == dad_pkg::MONTH_FIRST) && (d_ff == dad_pkg::DAY_FIRST) &&
                      (n_ext >= CMP_W'(ylen));
   assign fits_month = n_ext <= CMP_W'(left);

   always_comb begin
      unique case (uw.cond)
         dad_pkg::C_NEVER:     jump = 1'b0;
         dad_pkg::C_ALWAYS:    jump = 1'b1;
         dad_pkg::C_BAD:       jump = bad;
         dad_pkg::C_ZERO:      jump = (n_ff == '0);
         dad_pkg::C_YEAR_FITS: jump = year_fits;
         dad_pkg::C_NO_OVF:    jump = !ovf_ff;
         default:              jump = 1'b0;
      endcase
   end

   always_comb begin
      running_in   = running_ff;
      pc_in        = pc_ff;
      y_in         = y_ff;
      m_in         = m_ff;
      d_in         = d_ff;
      n_in         = n_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      ovf_in       = ovf_ff;
      st_in        = st_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (accept) begin
         running_in = 1'b1;
         pc_in      = dad_pkg::PC_DIV;
         y_in       = req_data.start_year;
         m_in       = req_data.start_month;
         d_in       = req_data.start_day;
         n_in       = n_wide[DAY_COUNT_BITS-1:0];
         ovf_in     = 1'b0;
         st_in      = dad_pkg::ST_OK;
      end else if (running_ff) begin
         pc_in = jump ? uw.target : pc_ff + 4'd1;
         case (uw.op)
            dad_pkg::OP_DIV: begin
               q_in = prod[dad_pkg::DIV100_SHIFT +: 8];
            end
            dad_pkg::OP_REM: begin
               r_in = r_calc[6:0];
            end
            dad_pkg::OP_YEAR: begin
               n_in = DAY_COUNT_BITS'(n_ext - CMP_W'(ylen));
               if (y_ff == dad_pkg::YEAR_MAX) begin
                  ovf_in = 1'b1;
               end else begin
                  y_in = y_ff + 14'd1;
                  if (r_ff == dad_pkg::CENTURY_END) begin
                     r_in = '0;
                     q_in = q_ff + 8'd1;
                  end else begin
                     r_in = r_ff + 7'd1;
                  end
               end
            end
            dad_pkg::OP_MONTH: begin
               if (fits_month) begin
                  d_in = d_ff + n_ff[4:0];
                  n_in = '0;
               end else begin
                  n_in = DAY_COUNT_BITS'(n_ext - CMP_W'(left) - CMP_W'(1));
                  d_in = dad_pkg::DAY_FIRST;
                  if (m_ff == dad_pkg::MONTH_LAST) begin
                     if (y_ff == dad_pkg::YEAR_MAX) begin
                        ovf_in = 1'b1;
                     end else begin
                        m_in = dad_pkg::MONTH_FIRST;
                        y_in = y_ff + 14'd1;
                        if (r_ff == dad_pkg::CENTURY_END) begin
                           r_in = '0;
                           q_in = q_ff + 8'd1;
                        end else begin
                           r_in = r_ff + 7'd1;
                        end
                     end
                  end else begin
                     m_in = m_ff + 4'd1;
                  end
               end
            end
            dad_pkg::OP_SAT: begin
               y_in  = dad_pkg::YEAR_MAX;
               m_in  = dad_pkg::MONTH_LAST;
               d_in  = dad_pkg::DAY_LAST;
               st_in = dad_pkg::ST_OVF;
            end
            dad_pkg::OP_BAD: begin
               y_in  = '0;
               m_in  = '0;
               d_in  = '0;
               st_in = dad_pkg::ST_BAD;
            end
            dad_pkg::OP_DONE: begin
               running_in   = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in       = '{result_year: y_ff, result_month: m_ff,
                                result_day: d_ff, status: st_ff};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         pc_ff        <= dad_pkg::PC_DIV;
         ovf_ff       <= 1'b0;
         st_ff        <= dad_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         running_ff   <= running_in;
         pc_ff        <= pc_in;
         ovf_ff       <= ovf_in;
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff   <= y_in;
      m_ff   <= m_in;
      d_ff   <= d_in;
      n_ff   <= n_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = running_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted without going busy");

   a_rsp_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("response outside of a running request");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == dad_pkg::ST_OVF |->
         rsp_data.result_year == dad_pkg::YEAR_MAX &&
         rsp_data.result_month == dad_pkg::MONTH_LAST &&
         rsp_data.result_day == dad_pkg::DAY_LAST)
      else $error("overflow result not saturated");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == dad_pkg::ST_BAD |->
         rsp_data.result_year == '0 && rsp_data.result_month == '0 &&
         rsp_data.result_day == '0)
      else $error("invalid-date result not cleared");
`endif

endmodule

`default_nettype wire
